// ===== rtl/core/qsb_pkg.sv =====
// ----------------------------------------------------------------------------
// qsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package qsb_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int QUEUES_DEF  = 4;
  localparam int DATA_W      = 32;
  localparam int QSEL_W      = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } qsb_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } qsb_status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_LINK,
    S_DEQ
  } qsb_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/qsb_intf.sv =====
// ----------------------------------------------------------------------------
// qsb_intf
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsb_in_if import qsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [QSEL_W-1:0]        queue_select;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output action, output queue_select, output data_in,
                  input ready);
  modport sink   (input valid, input action, input queue_select, input data_in,
                  output ready);
endinterface

interface qsb_out_if import qsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qsb_ram.sv =====
// ----------------------------------------------------------------------------
// qsb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/multi_queue_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core
// Several FIFO queues sharing one entry store through a linked free list.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A full enqueue, an empty dequeue and
// an enqueue into an empty queue answer from S_LOOK; an enqueue into a
// non-empty queue goes on to S_LINK, since the old tail's link and the new
// entry's link both go through the single write port of the link store; a
// dequeue goes on to S_DEQ, as the head pointer must come out of the queue
// table before the link and data stores can be read at it. A new request is
// taken while the previous result still waits in the output register. After
// reset a clearing pass builds the free list and empties the queue table; no
// request is taken meanwhile.
`default_nettype none

module multi_queue_shared_buffer_core import qsb_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int QUEUES  = QUEUES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qsb_in_if.sink    in_ch,
  qsb_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int PTR_W  = IDX_W + 1;
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int SWEEP  = (ENTRIES > QUEUES) ? ENTRIES : QUEUES;
  localparam int CNT_W  = $clog2(SWEEP + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  qsb_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         init_cnt_r, init_cnt_nxt;
  logic [PTR_W-1:0]         free_head_r, free_head_nxt;
  logic                     act_r, act_nxt;
  logic [QSEL_W-1:0]        q_r, q_nxt;
  logic [DATA_W-1:0]        data_r, data_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  qsb_status_t              out_status_r, out_status_nxt;

  logic                     link_we, link_re;
  logic [IDX_W-1:0]         link_waddr, link_raddr;
  logic [PTR_W-1:0]         link_wdata, link_rdata;
  logic                     data_we, data_re;
  logic [IDX_W-1:0]         data_waddr, data_raddr;
  logic [DATA_W-1:0]        data_wdata, data_rdata;
  logic                     qt_we, qt_re;
  logic [QIDX_W-1:0]        qt_waddr, qt_raddr;
  logic [2*PTR_W-1:0]       qt_wdata, qt_rdata;

  logic [PTR_W-1:0]         qh, qt;
  logic                     q_ok, out_free, in_xfer;

  qsb_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  qsb_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .re(data_re), .raddr(data_raddr), .rdata(data_rdata)
  );

  qsb_ram #(.WIDTH(2*PTR_W), .DEPTH(QUEUES)) u_queue_ram (
    .clk(clk), .we(qt_we), .waddr(qt_waddr), .wdata(qt_wdata),
    .re(qt_re), .raddr(qt_raddr), .rdata(qt_rdata)
  );

  assign qh       = qt_rdata[2*PTR_W-1:PTR_W];
  assign qt       = qt_rdata[PTR_W-1:0];
  assign q_ok     = (32'(q_r) < QUEUES);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.status   = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    q_r          <= q_nxt;
    data_r       <= data_nxt;
    idx_r        <= idx_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    free_head_nxt  = free_head_r;
    act_nxt        = act_r;
    q_nxt          = q_r;
    data_nxt       = data_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = '0;
    data_we    = 1'b0;
    data_waddr = '0;
    data_wdata = '0;
    data_re    = 1'b0;
    data_raddr = '0;
    qt_we      = 1'b0;
    qt_waddr   = '0;
    qt_wdata   = '0;
    qt_re      = 1'b0;
    qt_raddr   = '0;

    unique case (state_r)
      S_INIT: begin
        if (init_cnt_r < CNT_W'(ENTRIES)) begin
          link_we    = 1'b1;
          link_waddr = init_cnt_r[IDX_W-1:0];
          link_wdata = PTR_W'({1'b0, init_cnt_r} + 1'b1);
        end
        if (init_cnt_r < CNT_W'(QUEUES)) begin
          qt_we    = 1'b1;
          qt_waddr = init_cnt_r[QIDX_W-1:0];
          qt_wdata = {NIL, NIL};
        end
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == CNT_W'(SWEEP - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          act_nxt    = in_ch.action;
          q_nxt      = in_ch.queue_select;
          data_nxt   = in_ch.data_in;
          qt_re      = 1'b1;
          qt_raddr   = QIDX_W'(in_ch.queue_select);
          link_re    = 1'b1;
          link_raddr = free_head_r[IDX_W-1:0];
          state_nxt  = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          if (act_r == ACT_ENQ) begin
            if (!q_ok || (free_head_r >= NIL)) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_status_nxt = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              idx_nxt       = free_head_r[IDX_W-1:0];
              free_head_nxt = link_rdata;
              link_we       = 1'b1;
              link_waddr    = free_head_r[IDX_W-1:0];
              link_wdata    = NIL;
              data_we       = 1'b1;
              data_waddr    = free_head_r[IDX_W-1:0];
              data_wdata    = data_r;
              qt_we         = 1'b1;
              qt_waddr      = QIDX_W'(q_r);
              qt_wdata      = {((qh < NIL) ? qh : free_head_r), free_head_r};
              if ((qh < NIL) && (qt < NIL)) begin
                state_nxt = S_LINK;
              end else begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = ST_OK;
                state_nxt      = S_IDLE;
              end
            end
          end else begin
            if (!q_ok || (qh >= NIL)) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_status_nxt = ST_EMPTY;
              state_nxt      = S_IDLE;
            end else begin
              link_re    = 1'b1;
              link_raddr = qh[IDX_W-1:0];
              data_re    = 1'b1;
              data_raddr = qh[IDX_W-1:0];
              state_nxt  = S_DEQ;
            end
          end
        end
      end

      S_LINK: begin
        if (out_free) begin
          link_we        = 1'b1;
          link_waddr     = qt[IDX_W-1:0];
          link_wdata     = {1'b0, idx_r};
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_DEQ: begin
        if (out_free) begin
          qt_we          = 1'b1;
          qt_waddr       = QIDX_W'(q_r);
          qt_wdata       = {link_rdata, qt};
          link_we        = 1'b1;
          link_waddr     = qh[IDX_W-1:0];
          link_wdata     = free_head_r;
          free_head_nxt  = qh;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = data_rdata;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/qsb_chk.sv =====
// ----------------------------------------------------------------------------
// qsb_chk
// Port-level checks on the multi-queue shared buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qsb_chk import qsb_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] out_data,
  input wire logic [STATUS_W-1:0]      out_status
);

  logic [1:0] cnt_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // one request at a time: never ready straight after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_data == '0))
    else $error("full or empty answer carries data");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 2'd0))
    else $error("result without request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("too many requests outstanding");

endmodule

bind multi_queue_shared_buffer_core qsb_chk u_qsb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_out),
  .out_status(out_ch.status)
);

`default_nettype wire
